FILE: hw/rtl/bpsk_llr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpsk_llr_pkg: shared types and constants
// Register codes, configuration and control structs, fixed-point widths for
// the noisy BPSK LLR metric generator.
// ----------------------------------------------------------------------------
package bpsk_llr_pkg;

  localparam int LANES           = 8;
  localparam int Z_MAX_DEF       = 256;
  localparam int MAX_COLUMNS_DEF = 128;
  localparam int METRIC_BITS_DEF = 8;

  localparam int PUNCT_FIRST_COL = 69 - 2;
  localparam int RX_ONE_SHIFT    = 25;
  localparam int FRAC_BITS       = 33;
  localparam int NOISE_W         = 16;
  localparam int GAIN_W          = 16;
  localparam int FACTOR_W        = 18;
  localparam int LIMIT_W         = 7;
  localparam int PROD_W          = 32;
  localparam int RX_W            = 33;
  localparam int SC_W            = 52;
  localparam int ERRS_W          = 4;
  localparam int TOTAL_W         = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_Z_SIZE          = 3'd0,
    REG_NUM_COLUMNS     = 3'd1,
    REG_NUM_CODEWORDS   = 3'd2,
    REG_PUNCTURE_ENABLE = 3'd3,
    REG_NOISE_GAIN      = 3'd4,
    REG_LLR_FACTOR      = 3'd5,
    REG_LLR_LIMIT       = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [8:0]          z_size;
    logic [7:0]          num_columns;
    logic [31:0]         num_codewords;
    logic                puncture_enable;
    logic [GAIN_W-1:0]   noise_gain;
    logic [FACTOR_W-1:0] llr_factor;
    logic [LIMIT_W-1:0]  llr_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    z_size:          9'd256,
    num_columns:     8'd69,
    num_codewords:   32'd1,
    puncture_enable: 1'b0,
    noise_gain:      16'd16384,
    llr_factor:      18'd512,
    llr_limit:       7'd127
  };

  typedef struct packed {
    logic             valid;
    logic [LANES-1:0] act;
    logic             punct;
    logic             last_run;
  } ctl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bpsk_llr_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpsk_llr_in_if: input channel
// Encoded byte and eight noise samples with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpsk_llr_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        enc_byte;
  logic signed [15:0] noise_0;
  logic signed [15:0] noise_1;
  logic signed [15:0] noise_2;
  logic signed [15:0] noise_3;
  logic signed [15:0] noise_4;
  logic signed [15:0] noise_5;
  logic signed [15:0] noise_6;
  logic signed [15:0] noise_7;

  modport source (
    output valid, enc_byte, noise_0, noise_1, noise_2, noise_3,
           noise_4, noise_5, noise_6, noise_7,
    input  ready
  );

  modport sink (
    input  valid, enc_byte, noise_0, noise_1, noise_2, noise_3,
           noise_4, noise_5, noise_6, noise_7,
    output ready
  );
endinterface
`default_nettype wire

FILE: hw/rtl/bpsk_llr_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpsk_llr_out_if: output channel
// Eight metrics, error counts and end-of-run flag with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpsk_llr_out_if #(
  parameter int METRIC_BITS = 8
);
  logic                          valid;
  logic                          ready;
  logic signed [METRIC_BITS-1:0] metric_0;
  logic signed [METRIC_BITS-1:0] metric_1;
  logic signed [METRIC_BITS-1:0] metric_2;
  logic signed [METRIC_BITS-1:0] metric_3;
  logic signed [METRIC_BITS-1:0] metric_4;
  logic signed [METRIC_BITS-1:0] metric_5;
  logic signed [METRIC_BITS-1:0] metric_6;
  logic signed [METRIC_BITS-1:0] metric_7;
  logic [3:0]                    bit_errors;
  logic [31:0]                   error_total;
  logic                          final_res;

  modport source (
    output valid, metric_0, metric_1, metric_2, metric_3, metric_4,
           metric_5, metric_6, metric_7, bit_errors, error_total, final_res,
    input  ready
  );

  modport sink (
    input  valid, metric_0, metric_1, metric_2, metric_3, metric_4,
           metric_5, metric_6, metric_7, bit_errors, error_total, final_res,
    output ready
  );
endinterface
`default_nettype wire

FILE: hw/rtl/bpsk_llr_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpsk_llr_seq: configuration registers and position sequencer
// Holds the register file and the byte, column and codeword counters; issues
// per-transaction lane mask, puncture and end-of-run control.
// ----------------------------------------------------------------------------
module bpsk_llr_seq #(
  parameter int Z_MAX       = bpsk_llr_pkg::Z_MAX_DEF,
  parameter int MAX_COLUMNS = bpsk_llr_pkg::MAX_COLUMNS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [bpsk_llr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [bpsk_llr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                                  adv_i,
  input  wire logic                                  accept_i,
  output bpsk_llr_pkg::cfg_t                         cfg_o,
  output bpsk_llr_pkg::ctl_t                         ctl_o
);

  localparam int BYTE_W = (Z_MAX > 8) ? $clog2(Z_MAX / 8) : 1;
  localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  bpsk_llr_pkg::cfg_t cfg_q, cfg_d;
  bpsk_llr_pkg::ctl_t ctl_q, ctl_d;

  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [31:0]       cw_q, cw_d;

  logic [8:0]  z_eff, zm1, last_byte_idx, ncol_eff, ncol_ext;
  logic [31:0] ncw_m1;
  logic        last_byte, last_col, last_cw, punct;
  logic [bpsk_llr_pkg::LANES-1:0] act;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpsk_llr_pkg::REG_Z_SIZE:          cfg_d.z_size          = cfg_data_i[8:0];
        bpsk_llr_pkg::REG_NUM_COLUMNS:     cfg_d.num_columns     = cfg_data_i[7:0];
        bpsk_llr_pkg::REG_NUM_CODEWORDS:   cfg_d.num_codewords   = cfg_data_i[31:0];
        bpsk_llr_pkg::REG_PUNCTURE_ENABLE: cfg_d.puncture_enable = cfg_data_i[0];
        bpsk_llr_pkg::REG_NOISE_GAIN:      cfg_d.noise_gain      = cfg_data_i[15:0];
        bpsk_llr_pkg::REG_LLR_FACTOR:      cfg_d.llr_factor      = cfg_data_i[17:0];
        bpsk_llr_pkg::REG_LLR_LIMIT:       cfg_d.llr_limit       = cfg_data_i[6:0];
        default:                           cfg_d                 = cfg_q;
      endcase
    end
  end

  always_comb begin
    if (cfg_q.z_size == 9'd0) begin
      z_eff = 9'd1;
    end else if (cfg_q.z_size > 9'(Z_MAX)) begin
      z_eff = 9'(Z_MAX);
    end else begin
      z_eff = cfg_q.z_size;
    end
    zm1           = z_eff - 9'd1;
    last_byte_idx = zm1 >> 3;

    ncol_ext = {1'b0, cfg_q.num_columns};
    if (ncol_ext == 9'd0) begin
      ncol_eff = 9'd1;
    end else if (ncol_ext > 9'(MAX_COLUMNS)) begin
      ncol_eff = 9'(MAX_COLUMNS);
    end else begin
      ncol_eff = ncol_ext;
    end

    ncw_m1 = (cfg_q.num_codewords == 32'd0) ? 32'd0 : cfg_q.num_codewords - 32'd1;

    last_byte = 9'(byte_q) >= last_byte_idx;
    last_col  = 9'(col_q) >= (ncol_eff - 9'd1);
    last_cw   = cw_q >= ncw_m1;
    punct     = cfg_q.puncture_enable && (9'(col_q) >= 9'(bpsk_llr_pkg::PUNCT_FIRST_COL));

    for (int i = 0; i < bpsk_llr_pkg::LANES; i++) begin
      act[i] = !last_byte || (3'(i) <= zm1[2:0]);
    end
  end

  always_comb begin
    byte_d = byte_q;
    col_d  = col_q;
    cw_d   = cw_q;
    if (accept_i) begin
      if (!last_byte) begin
        byte_d = byte_q + BYTE_W'(1);
      end else begin
        byte_d = '0;
        if (!last_col) begin
          col_d = col_q + COL_W'(1);
        end else begin
          col_d = '0;
          cw_d  = last_cw ? 32'd0 : cw_q + 32'd1;
        end
      end
    end

    ctl_d = ctl_q;
    if (adv_i) begin
      ctl_d.valid    = accept_i;
      ctl_d.act      = act;
      ctl_d.punct    = punct;
      ctl_d.last_run = last_byte && last_col && last_cw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= bpsk_llr_pkg::CFG_RESET;
      ctl_q  <= '0;
      byte_q <= '0;
      col_q  <= '0;
      cw_q   <= '0;
    end else begin
      cfg_q  <= cfg_d;
      ctl_q  <= ctl_d;
      byte_q <= byte_d;
      col_q  <= col_d;
      cw_q   <= cw_d;
    end
  end

  assign cfg_o = cfg_q;
  assign ctl_o = ctl_q;

endmodule
`default_nettype wire

FILE: hw/rtl/bpsk_llr_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpsk_llr_lane: one BPSK lane
// Noise scaling, symbol add and error detect, LLR scaling, then clamp and
// round-half-even to the metric. Four registered stages.
// ----------------------------------------------------------------------------
module bpsk_llr_lane #(
  parameter int METRIC_BITS = bpsk_llr_pkg::METRIC_BITS_DEF
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       adv_i,
  input  wire logic signed [bpsk_llr_pkg::NOISE_W-1:0]    noise_i,
  input  wire logic                                       bit_i,
  input  wire logic                                       act_i,
  input  wire logic                                       punct_i,
  input  wire logic [bpsk_llr_pkg::GAIN_W-1:0]            noise_gain_i,
  input  wire logic [bpsk_llr_pkg::FACTOR_W-1:0]          llr_factor_i,
  input  wire logic [bpsk_llr_pkg::LIMIT_W-1:0]           llr_limit_i,
  output logic                                            err_o,
  output logic signed [METRIC_BITS-1:0]                   metric_o
);

  localparam int RX_W = bpsk_llr_pkg::RX_W;
  localparam int SC_W = bpsk_llr_pkg::SC_W;
  localparam int FB   = bpsk_llr_pkg::FRAC_BITS;
  localparam logic signed [RX_W-1:0] RX_POS = RX_W'(1) << bpsk_llr_pkg::RX_ONE_SHIFT;
  localparam logic signed [RX_W-1:0] RX_NEG = -RX_POS;
  localparam logic [FB-1:0]          HALF   = {1'b1, {(FB-1){1'b0}}};

  logic signed [bpsk_llr_pkg::PROD_W:0]   prod_d;
  logic signed [bpsk_llr_pkg::PROD_W-1:0] prod_q;
  logic                                   bit_q;

  logic signed [RX_W-1:0] rx_sum, rx_q;
  logic                   err_d, err_q;

  logic signed [SC_W-1:0] sc_prod, sc_q;

  logic                   neg, up;
  logic [SC_W-1:0]        mag, lim;
  logic [7:0]             q, q_rnd;
  logic [FB-1:0]          rem;
  logic [15:0]            mval;
  logic signed [METRIC_BITS-1:0] metric_d, metric_q;

  always_comb begin
    prod_d  = noise_i * $signed({1'b0, noise_gain_i});
    rx_sum  = RX_W'(prod_q) + (bit_q ? RX_NEG : RX_POS);
    err_d   = act_i && (rx_sum[RX_W-1] != bit_q);
    sc_prod = rx_q * $signed({1'b0, llr_factor_i});

    neg = sc_q[SC_W-1];
    mag = neg ? SC_W'(-sc_q) : SC_W'(sc_q);
    lim = SC_W'({llr_limit_i, {FB{1'b0}}});
    q   = mag[FB+7:FB];
    rem = mag[FB-1:0];
    if (mag >= lim) begin
      q  = {1'b0, llr_limit_i};
      up = 1'b0;
    end else begin
      up = (rem > HALF) || ((rem == HALF) && q[0]);
    end
    q_rnd    = q + 8'(up);
    mval     = neg ? -{8'd0, q_rnd} : {8'd0, q_rnd};
    metric_d = mval[METRIC_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q   <= prod_d[bpsk_llr_pkg::PROD_W-1:0];
      bit_q    <= bit_i;
      rx_q     <= act_i ? rx_sum : '0;
      err_q    <= err_d;
      sc_q     <= punct_i ? '0 : sc_prod;
      metric_q <= metric_d;
    end
  end

  assign err_o    = err_q;
  assign metric_o = metric_q;

endmodule
`default_nettype wire

FILE: hw/rtl/bpsk_llr_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpsk_llr_merge: error merge and output status
// Counts lane errors, keeps the running error total across a run and aligns
// the status fields and valid with the lane metrics.
// ----------------------------------------------------------------------------
module bpsk_llr_merge (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  adv_i,
  input  wire bpsk_llr_pkg::ctl_t                    ctl_i,
  input  wire logic [bpsk_llr_pkg::LANES-1:0]        err_i,
  output logic                                       valid_o,
  output logic [bpsk_llr_pkg::ERRS_W-1:0]            bit_errors_o,
  output logic [bpsk_llr_pkg::TOTAL_W-1:0]           error_total_o,
  output logic                                       final_res_o
);

  localparam int EW = bpsk_llr_pkg::ERRS_W;
  localparam int TW = bpsk_llr_pkg::TOTAL_W;

  logic [EW-1:0] errs_d, errs3_q, errs4_q;
  logic [TW-1:0] tot_d, tot3_q, tot4_q, acc_q;
  logic          v3_q, v4_q, fin3_q, fin4_q;

  always_comb begin
    errs_d = '0;
    for (int i = 0; i < bpsk_llr_pkg::LANES; i++) begin
      errs_d = errs_d + EW'(err_i[i]);
    end
    tot_d = acc_q + TW'(errs_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      fin3_q <= 1'b0;
      fin4_q <= 1'b0;
      acc_q  <= '0;
    end else if (adv_i) begin
      v3_q   <= ctl_i.valid;
      v4_q   <= v3_q;
      fin3_q <= ctl_i.last_run;
      fin4_q <= fin3_q;
      if (ctl_i.valid) begin
        acc_q <= ctl_i.last_run ? '0 : tot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      errs3_q <= errs_d;
      tot3_q  <= tot_d;
      errs4_q <= errs3_q;
      tot4_q  <= tot3_q;
    end
  end

  assign valid_o       = v4_q;
  assign bit_errors_o  = errs4_q;
  assign error_total_o = tot4_q;
  assign final_res_o   = fin4_q;

endmodule
`default_nettype wire

FILE: hw/rtl/bpsk_noisy_llr_metric_gen_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpsk_noisy_llr_metric_gen_top: noisy BPSK channel and LLR metric generator
// Eight parallel lanes turn one encoded byte plus noise into eight metrics.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one transaction = enc_byte and noise_0..noise_7 (bit i -> lane i).
//   out_if : one transaction = metric_0..metric_7, bit_errors, error_total,
//            final_res for each input transaction, in order.
//   cfg    : cfg_we_i/cfg_idx_i/cfg_data_i write registers 0..6 (z_size,
//            num_columns, num_codewords, puncture_enable, noise_gain,
//            llr_factor, llr_limit). Write only while the pipeline is empty.
//   Throughput: one transaction per cycle unless the output stalls; the four
//   lane stages (noise multiply, symbol add, LLR multiply, clamp/round) and
//   the error merge all advance together.
//   Stall: in_if.ready = !out_if.valid || out_if.ready; a stalled receiver
//   freezes every stage, nothing is dropped.
//   Reset: registers return to 256/69/1/0/16384/512/127, position counters
//   and error total clear, pipeline empties. No clearing pass is needed.
//   final_res marks the last byte of the last codeword; the run state then
//   restarts from zero.
// ----------------------------------------------------------------------------
module bpsk_noisy_llr_metric_gen_top #(
  parameter int Z_MAX       = bpsk_llr_pkg::Z_MAX_DEF,
  parameter int MAX_COLUMNS = bpsk_llr_pkg::MAX_COLUMNS_DEF,
  parameter int METRIC_BITS = bpsk_llr_pkg::METRIC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [bpsk_llr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [bpsk_llr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bpsk_llr_in_if.sink                              in_if,
  bpsk_llr_out_if.source                           out_if
);

  localparam int LANES = bpsk_llr_pkg::LANES;

  logic adv, accept, out_valid;

  bpsk_llr_pkg::cfg_t cfg;
  bpsk_llr_pkg::ctl_t ctl1, ctl2_q;

  logic signed [bpsk_llr_pkg::NOISE_W-1:0] noise [LANES];
  logic signed [METRIC_BITS-1:0]           metric [LANES];
  logic [LANES-1:0]                        err;

  assign adv    = !out_valid || out_if.ready;
  assign accept = in_if.valid && adv;
  assign in_if.ready = adv;

  assign noise[0] = in_if.noise_0;
  assign noise[1] = in_if.noise_1;
  assign noise[2] = in_if.noise_2;
  assign noise[3] = in_if.noise_3;
  assign noise[4] = in_if.noise_4;
  assign noise[5] = in_if.noise_5;
  assign noise[6] = in_if.noise_6;
  assign noise[7] = in_if.noise_7;

  bpsk_llr_seq #(
    .Z_MAX       (Z_MAX),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .adv_i      (adv),
    .accept_i   (accept),
    .cfg_o      (cfg),
    .ctl_o      (ctl1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
    end else if (adv) begin
      ctl2_q <= ctl1;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bpsk_llr_lane #(
      .METRIC_BITS (METRIC_BITS)
    ) u_lane (
      .clk_i        (clk_i),
      .adv_i        (adv),
      .noise_i      (noise[g]),
      .bit_i        (in_if.enc_byte[g]),
      .act_i        (ctl1.act[g]),
      .punct_i      (ctl2_q.punct),
      .noise_gain_i (cfg.noise_gain),
      .llr_factor_i (cfg.llr_factor),
      .llr_limit_i  (cfg.llr_limit),
      .err_o        (err[g]),
      .metric_o     (metric[g])
    );
  end

  bpsk_llr_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .ctl_i         (ctl2_q),
    .err_i         (err),
    .valid_o       (out_valid),
    .bit_errors_o  (out_if.bit_errors),
    .error_total_o (out_if.error_total),
    .final_res_o   (out_if.final_res)
  );

  assign out_if.valid    = out_valid;
  assign out_if.metric_0 = metric[0];
  assign out_if.metric_1 = metric[1];
  assign out_if.metric_2 = metric[2];
  assign out_if.metric_3 = metric[3];
  assign out_if.metric_4 = metric[4];
  assign out_if.metric_5 = metric[5];
  assign out_if.metric_6 = metric[6];
  assign out_if.metric_7 = metric[7];

endmodule
`default_nettype wire

FILE: hw/rtl/bpsk_llr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpsk_llr_checker: port-level assertions
// Checks reset, ready behavior, error bookkeeping and metric range at the
// top-level ports.
// ----------------------------------------------------------------------------
module bpsk_llr_checker #(
  parameter int METRIC_BITS = bpsk_llr_pkg::METRIC_BITS_DEF
) (
  input wire logic                                         clk_i,
  input wire logic                                         rst_ni,
  input wire logic                                         in_ready,
  input wire logic                                         out_valid,
  input wire logic                                         out_ready,
  input wire logic [bpsk_llr_pkg::LANES*METRIC_BITS-1:0]   metrics,
  input wire logic [3:0]                                   bit_errors,
  input wire logic [31:0]                                  error_total,
  input wire logic                                         final_res
);

  localparam logic [METRIC_BITS-1:0] MOST_NEG = {1'b1, {(METRIC_BITS-1){1'b0}}};

  logic [31:0] base_q;
  logic        metric_bad;

  always_comb begin
    metric_bad = 1'b0;
    for (int i = 0; i < bpsk_llr_pkg::LANES; i++) begin
      metric_bad = metric_bad || (metrics[i*METRIC_BITS +: METRIC_BITS] == MOST_NEG);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (out_valid && out_ready) begin
      base_q <= final_res ? 32'd0 : error_total;
    end
  end

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid)
    else $error("output valid during reset");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_total_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready) |-> (error_total == base_q + 32'(bit_errors)))
    else $error("error total does not follow per-transaction errors");

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> ((bit_errors <= 4'd8) && !metric_bad))
    else $error("bit error count or metric out of range");

endmodule

bind bpsk_noisy_llr_metric_gen_top bpsk_llr_checker #(
  .METRIC_BITS (METRIC_BITS)
) u_bpsk_llr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .metrics     ({out_if.metric_7, out_if.metric_6, out_if.metric_5, out_if.metric_4,
                 out_if.metric_3, out_if.metric_2, out_if.metric_1, out_if.metric_0}),
  .bit_errors  (out_if.bit_errors),
  .error_total (out_if.error_total),
  .final_res   (out_if.final_res)
);
`default_nettype wire
